@@ sv/ght_pkg.sv @@
`default_nettype none

package ght_pkg;

    localparam int unsigned DEF_ENTRIES     = 256;
    localparam int unsigned DEF_REV_WIDTH   = 16;
    localparam int unsigned DEF_COUNT_WIDTH = 16;
    localparam int unsigned DEF_DATA_WIDTH  = 64;

    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_GET     = 3'd1,
        CMD_REF     = 3'd2,
        CMD_UNREF   = 3'd3,
        CMD_IS_DEAD = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_BAD_INDEX   = 3'd2,
        ST_STALE       = 3'd3,
        ST_COUNT_LIMIT = 3'd4,
        ST_FUTURE      = 3'd5
    } t_status;

endpackage

`default_nettype wire

@@ sv/generational_handle_table.sv @@
// An accepted request reads its slot and is captured; its result is registered once the output
// is free. No new request is taken until then, set by the read-modify-write of the slot memory
// (read at acceptance, write back with the result); a stalled result holds the next request.
// Reset: synchronous, active low; clears the sequencer, the result valid, the free-list head
// and the fill count. The slot memory is not cleared: slots at or above the fill count have
// been written, those below read as fresh (revision 1, count 0), so no clearing pass is needed.
`default_nettype none

module generational_handle_table
    import ght_pkg::*;
#(
    parameter int unsigned ENTRIES     = DEF_ENTRIES,
    parameter int unsigned REV_WIDTH   = DEF_REV_WIDTH,
    parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int unsigned DATA_WIDTH  = DEF_DATA_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_slot_index,
    input  wire logic [15:0] i_handle_revision,
    input  wire logic [63:0] i_item_data,
    input  wire logic [7:0]  i_drop_kind,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [7:0]       o_out_index,
    output logic [15:0]      o_out_revision,
    output logic [63:0]      o_out_data,
    output logic [7:0]       o_out_drop_kind,
    output logic             o_dropped,
    output logic             o_dead
);

    localparam int unsigned IDX_W  = $clog2(ENTRIES);
    localparam int unsigned LINK_W = $clog2(ENTRIES + 1);
    localparam logic [LINK_W-1:0] LIST_END = LINK_W'(ENTRIES);

    typedef struct packed {
        logic [REV_WIDTH-1:0]   rev;
        logic [COUNT_WIDTH-1:0] count;
        logic [LINK_W-1:0]      link;
        logic [7:0]             tag;
        logic [DATA_WIDTH-1:0]  data;
    } t_slot;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    // slot memory
    t_slot            r_mem [ENTRIES];
    t_slot            r_rd;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    t_slot            wr_word;

    // control and captured request
    t_state                r_state;
    logic [LINK_W-1:0]     r_head, n_head;
    logic [LINK_W-1:0]     r_fill, n_fill;
    t_cmd                  r_cmd;
    logic [IDX_W-1:0]      r_slot;
    logic                  r_bad;
    logic                  r_full;
    logic [REV_WIDTH-1:0]  r_hrev;
    logic [DATA_WIDTH-1:0] r_data;
    logic [7:0]            r_tag;

    // result register
    logic                  r_out_valid;
    t_status               r_status, n_status;
    logic [IDX_W-1:0]      r_o_index, n_o_index;
    logic [REV_WIDTH-1:0]  r_o_rev, n_o_rev;
    logic [DATA_WIDTH-1:0] r_o_data, n_o_data;
    logic [7:0]            r_o_tag, n_o_tag;
    logic                  r_o_dropped, n_o_dropped;
    logic                  r_o_dead, n_o_dead;

    logic  accept;
    logic  done;
    logic  fresh;
    t_slot cur;
    t_cmd  in_cmd;
    logic [REV_WIDTH-1:0] next_rev;

    assign in_cmd  = t_cmd'(i_command);
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign done    = (r_state == S_EXEC) && (!r_out_valid || i_ready);

    assign rd_en   = accept;
    assign rd_addr = (in_cmd == CMD_INSERT) ? IDX_W'(r_head) : IDX_W'(i_slot_index);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_slot] <= wr_word;
        end
    end

    // slots below the fill count have never been handed out
    assign fresh = LINK_W'(r_slot) < r_fill;

    always_comb begin
        cur = r_rd;
        if (fresh) begin
            cur.rev   = REV_WIDTH'(1);
            cur.count = '0;
            cur.link  = (r_slot == '0) ? LIST_END : LINK_W'(r_slot) - LINK_W'(1);
        end
    end

    assign next_rev = (cur.rev == '1) ? REV_WIDTH'(1) : cur.rev + REV_WIDTH'(1);

    always_comb begin
        n_status    = ST_OK;
        n_o_index   = '0;
        n_o_rev     = '0;
        n_o_data    = '0;
        n_o_tag     = '0;
        n_o_dropped = 1'b0;
        n_o_dead    = 1'b0;
        n_head      = r_head;
        n_fill      = r_fill;
        wr_en       = 1'b0;
        wr_word     = cur;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (r_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en         = done;
                    wr_word.count = COUNT_WIDTH'(1);
                    wr_word.data  = r_data;
                    wr_word.tag   = r_tag;
                    n_head        = cur.link;
                    if (fresh) begin
                        n_fill = LINK_W'(r_slot);
                    end
                    n_o_index = r_slot;
                    n_o_rev   = cur.rev;
                end
            end
            CMD_IS_DEAD: begin
                if (r_bad) begin
                    n_status = ST_BAD_INDEX;
                end else if (r_hrev > cur.rev) begin
                    n_status = ST_FUTURE;
                end else begin
                    n_o_dead = (r_hrev != cur.rev);
                end
            end
            CMD_GET, CMD_REF, CMD_UNREF: begin
                if (r_bad) begin
                    n_status = ST_BAD_INDEX;
                end else if (r_hrev != cur.rev || cur.count == '0) begin
                    n_status = ST_STALE;
                end else if (r_cmd == CMD_GET) begin
                    n_o_data = cur.data;
                end else if (r_cmd == CMD_REF) begin
                    if (cur.count == '1) begin
                        n_status = ST_COUNT_LIMIT;
                    end else begin
                        wr_en         = done;
                        wr_word.count = cur.count + COUNT_WIDTH'(1);
                    end
                end else begin
                    wr_en         = done;
                    wr_word.count = cur.count - COUNT_WIDTH'(1);
                    if (cur.count == COUNT_WIDTH'(1)) begin
                        // last reference gone: release and push on the free list
                        n_o_data      = cur.data;
                        n_o_tag       = cur.tag;
                        n_o_dropped   = 1'b1;
                        wr_word.rev   = next_rev;
                        wr_word.link  = r_head;
                        n_head        = LINK_W'(r_slot);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_head      <= LINK_W'(ENTRIES - 1);
            r_fill      <= LIST_END;
        end else begin
            if (i_ready && !done) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (done) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_head      <= n_head;
                        r_fill      <= n_fill;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= in_cmd;
            r_slot <= rd_addr;
            r_bad  <= 32'(i_slot_index) >= 32'(ENTRIES);
            r_full <= (r_head == LIST_END);
            r_hrev <= REV_WIDTH'(i_handle_revision);
            r_data <= DATA_WIDTH'(i_item_data);
            r_tag  <= i_drop_kind;
        end
        if (done) begin
            r_status    <= n_status;
            r_o_index   <= n_o_index;
            r_o_rev     <= n_o_rev;
            r_o_data    <= n_o_data;
            r_o_tag     <= n_o_tag;
            r_o_dropped <= n_o_dropped;
            r_o_dead    <= n_o_dead;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_out_index     = 8'(r_o_index);
    assign o_out_revision  = 16'(r_o_rev);
    assign o_out_data      = 64'(r_o_data);
    assign o_out_drop_kind = r_o_tag;
    assign o_dropped       = r_o_dropped;
    assign o_dead          = r_o_dead;

endmodule

`default_nettype wire

@@ sv/ght_checker.sv @@
`default_nettype none

module ght_checker
    import ght_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_status,
    input wire logic [7:0]  o_out_index,
    input wire logic [15:0] o_out_revision,
    input wire logic [63:0] o_out_data,
    input wire logic        o_dropped,
    input wire logic        o_dead
);

    // one request in flight: the sequencer is busy the cycle after acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while previous one still in flight");

    a_drop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> (o_status == ST_OK && !o_dead))
        else $error("release reported with bad status");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL)
            |-> (o_out_index == 8'd0 && o_out_revision == 16'd0 && o_out_data == 64'd0
                 && !o_dropped && !o_dead))
        else $error("full status with non-zero payload");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind generational_handle_table ght_checker u_ght_checker (.*);

`default_nettype wire

@@ tb/generational_handle_table_test.sv @@
`default_nettype none

module generational_handle_table_test;
    import ght_pkg::*;

    localparam int unsigned ENTRY_COUNT    = DEF_ENTRIES;
    localparam int unsigned LIST_END       = ENTRY_COUNT;
    localparam logic [15:0] REV_MAX        = '1;
    localparam logic [15:0] COUNT_MAX      = '1;
    localparam logic [2:0]  FIRST_SPARE_CMD = 3'd5;
    localparam int unsigned SPARE_CMDS     = 3;
    localparam int unsigned RANDOM_ITEMS   = 160;
    localparam int unsigned LONG_HOLD      = 200;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PRINT_CAP      = 100;

    typedef struct packed {
        t_status     status;
        logic [7:0]  index;
        logic [15:0] revision;
        logic [63:0] data;
        logic [7:0]  drop_kind;
        logic        dropped;
        logic        dead;
    } t_table_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_command = '0;
    logic [7:0]  i_slot_index = '0;
    logic [15:0] i_handle_revision = '0;
    logic [63:0] i_item_data = '0;
    logic [7:0]  i_drop_kind = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [7:0]  o_out_index;
    logic [15:0] o_out_revision;
    logic [63:0] o_out_data;
    logic [7:0]  o_out_drop_kind;
    logic        o_dropped;
    logic        o_dead;

    // shadow of the slot table
    logic [15:0] slot_rev  [ENTRY_COUNT];
    logic [15:0] slot_refs [ENTRY_COUNT];
    logic [63:0] slot_word [ENTRY_COUNT];
    logic [7:0]  slot_kind [ENTRY_COUNT];
    int unsigned free_next [ENTRY_COUNT];
    int unsigned free_top;

    t_table_result pending_results[$];
    int unsigned   error_count = 0;
    int unsigned   quiet_cycles = 0;
    bit            idle_on = 1'b0;
    bit            hold_results_long = 1'b0;

    always #5 i_clk = ~i_clk;

    generational_handle_table uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_command         (i_command),
        .i_slot_index      (i_slot_index),
        .i_handle_revision (i_handle_revision),
        .i_item_data       (i_item_data),
        .i_drop_kind       (i_drop_kind),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_out_index       (o_out_index),
        .o_out_revision    (o_out_revision),
        .o_out_data        (o_out_data),
        .o_out_drop_kind   (o_out_drop_kind),
        .o_dropped         (o_dropped),
        .o_dead            (o_dead)
    );

    function automatic void clear_slot_table();
        for (int k = 0; k < ENTRY_COUNT; k++) begin
            slot_rev[k]  = 16'd1;
            slot_refs[k] = '0;
            slot_word[k] = '0;
            slot_kind[k] = '0;
            free_next[k] = (k == 0) ? LIST_END : k - 1;
        end
        free_top = ENTRY_COUNT - 1;
    endfunction

    // revision zero is never handed out
    function automatic logic [15:0] bump_revision(logic [15:0] rev);
        return (rev == REV_MAX) ? 16'd1 : rev + 16'd1;
    endfunction

    function automatic t_table_result apply_table_command(logic [2:0] cmd, logic [7:0] idx,
            logic [15:0] hrev, logic [63:0] word, logic [7:0] kind);
        t_table_result r;
        int unsigned   s;
        r = '0;
        case (cmd)
            CMD_INSERT: begin
                if (free_top >= LIST_END) begin
                    r.status = ST_FULL;
                end else begin
                    s = free_top;
                    free_top = free_next[s];
                    slot_word[s] = word;
                    slot_kind[s] = kind;
                    slot_refs[s] = 16'd1;
                    r.index = 8'(s);
                    r.revision = slot_rev[s];
                end
            end
            CMD_GET, CMD_REF, CMD_UNREF, CMD_IS_DEAD: begin
                if (32'(idx) >= ENTRY_COUNT) begin
                    r.status = ST_BAD_INDEX;
                end else if (cmd == CMD_IS_DEAD) begin
                    if (hrev > slot_rev[idx])
                        r.status = ST_FUTURE;
                    else
                        r.dead = (hrev != slot_rev[idx]);
                end else if (hrev != slot_rev[idx] || slot_refs[idx] == '0) begin
                    r.status = ST_STALE;
                end else if (cmd == CMD_GET) begin
                    r.data = slot_word[idx];
                end else if (cmd == CMD_REF) begin
                    if (slot_refs[idx] == COUNT_MAX)
                        r.status = ST_COUNT_LIMIT;
                    else
                        slot_refs[idx] = slot_refs[idx] + 16'd1;
                end else begin
                    slot_refs[idx] = slot_refs[idx] - 16'd1;
                    if (slot_refs[idx] == '0) begin
                        r.data = slot_word[idx];
                        r.drop_kind = slot_kind[idx];
                        r.dropped = 1'b1;
                        slot_rev[idx] = bump_revision(slot_rev[idx]);
                        free_next[idx] = free_top;
                        free_top = 32'(idx);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int find_live_slot();
        int unsigned start;
        int unsigned s;
        start = $urandom_range(0, ENTRY_COUNT - 1);
        for (int k = 0; k < ENTRY_COUNT; k++) begin
            s = (start + k) % ENTRY_COUNT;
            if (slot_refs[s] != '0)
                return int'(s);
        end
        return -1;
    endfunction

    // Valid stays high from one request to the next unless an idle burst or a wait for results lowers it.
    task automatic send_request(input logic [2:0] cmd, input logic [7:0] idx,
            input logic [15:0] hrev, input logic [63:0] word, input logic [7:0] kind,
            output t_table_result expected);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_command         <= cmd;
        i_slot_index      <= idx;
        i_handle_revision <= hrev;
        i_item_data       <= word;
        i_drop_kind       <= kind;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected = apply_table_command(cmd, idx, hrev, word, kind);
        pending_results.push_back(expected);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        t_table_result r;
        int            live;
        int unsigned   pick;
        logic [2:0]    cmd;
        logic [7:0]    idx;
        logic [15:0]   hrev;
        logic [63:0]   word;
        pick = $urandom_range(0, 99);
        live = find_live_slot();
        word = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            word = $urandom_range(0, 1) ? '1 : '0;
        // mostly handles that are really held, the rest stale or random
        if (live >= 0 && $urandom_range(0, 4) != 0) begin
            idx = 8'(live);
            hrev = slot_rev[idx];
        end else begin
            idx = 8'($urandom);
            case ($urandom_range(0, 2))
                0: hrev = 16'($urandom);
                1: hrev = slot_rev[idx] - 16'd1;
                default: hrev = slot_rev[idx] + 16'd1;
            endcase
        end
        if (live < 0 && pick < 80)
            pick = 0;
        if (pick < 20) begin
            cmd = CMD_INSERT;
        end else if (pick < 35) begin
            cmd = CMD_GET;
        end else if (pick < 50) begin
            cmd = CMD_REF;
        end else if (pick < 85) begin
            cmd = CMD_UNREF;
        end else if (pick < 95) begin
            cmd = CMD_IS_DEAD;
            if ($urandom_range(0, 1))
                hrev = 16'($urandom);
        end else begin
            cmd = 3'(FIRST_SPARE_CMD + $urandom_range(0, SPARE_CMDS - 1));
        end
        send_request(cmd, idx, hrev, word, 8'($urandom), r);
    endtask

    task automatic test_fresh_slots();
        t_table_result h;
        t_table_result h2;
        t_table_result r;
        send_request(CMD_IS_DEAD, 8'd0, 16'd1, '0, '0, r);
        send_request(CMD_IS_DEAD, 8'd255, 16'd0, '1, '1, r);
        send_request(CMD_IS_DEAD, 8'd128, 16'd2, '0, '0, r);
        send_request(CMD_IS_DEAD, 8'd7, REV_MAX, '1, '1, r);
        // matching revision but nothing inserted yet
        send_request(CMD_GET, 8'd0, 16'd1, '0, '0, r);
        send_request(CMD_REF, 8'd255, 16'd1, '0, '0, r);
        send_request(CMD_UNREF, 8'd255, 16'd1, '0, '0, r);
        send_request(CMD_INSERT, 8'd0, 16'd0, '1, 8'hFF, h);
        send_request(CMD_GET, h.index, h.revision, '0, '0, r);
        send_request(CMD_GET, h.index, h.revision + 16'd1, '0, '0, r);
        send_request(CMD_INSERT, 8'hFF, REV_MAX, '0, '0, h2);
        send_request(CMD_GET, h2.index, h2.revision, '1, '1, r);
        send_request(CMD_REF, h.index, h.revision, '0, '0, r);
        send_request(CMD_UNREF, h.index, h.revision, '0, '0, r);
        send_request(CMD_UNREF, h.index, h.revision, '0, '0, r);
        send_request(CMD_GET, h.index, h.revision, '0, '0, r);
        send_request(CMD_IS_DEAD, h.index, h.revision, '0, '0, r);
        send_request(CMD_UNREF, h2.index, h2.revision, '0, '0, r);
        send_request(CMD_INSERT, 8'd0, 16'd0, 64'h0123_4567_89AB_CDEF, 8'h5A, h);
        send_request(CMD_UNREF, h.index, h.revision, '0, '0, r);
        for (int k = 0; k < SPARE_CMDS; k++)
            send_request(3'(FIRST_SPARE_CMD + k), '1, '1, '1, '1, r);
        wait_for_results();
    endtask

    // half the slots stay held for the random traffic
    task automatic test_full_table();
        t_table_result r;
        int unsigned   order [ENTRY_COUNT];
        int unsigned   j;
        int unsigned   t;
        while (free_top != LIST_END)
            send_request(CMD_INSERT, 8'($urandom), 16'($urandom), {$urandom, $urandom},
                         8'($urandom), r);
        send_request(CMD_INSERT, 8'($urandom), 16'($urandom), '1, '1, r);
        for (int k = 0; k < 8; k++) begin
            j = $urandom_range(0, ENTRY_COUNT - 1);
            send_request(CMD_GET, 8'(j), slot_rev[j], '0, '0, r);
        end
        for (int k = 0; k < ENTRY_COUNT; k++)
            order[k] = k;
        for (int k = ENTRY_COUNT - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (int k = 0; k < ENTRY_COUNT / 2; k++)
            send_request(CMD_UNREF, 8'(order[k]), slot_rev[order[k]], '0, '0, r);
        wait_for_results();
    endtask

    task automatic test_result_backpressure();
        hold_results_long = 1'b1;
        repeat (24) send_random_request();
        wait_for_results();
        repeat (12) send_random_request();
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // idling in bursty stretches, none in the final quarter
            if (n % 40 == 0)
                idle_on = (n < RANDOM_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) == 0)
                wait_for_results();
            send_random_request();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
            input logic [63:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_table_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= PRINT_CAP)
                    $display("%0t: result with no request pending, expected none, actual %0h",
                             $time, o_status);
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("out_index", want.index, o_out_index);
                check_field("out_revision", want.revision, o_out_revision);
                check_field("out_data", want.data, o_out_data);
                check_field("out_drop_kind", want.drop_kind, o_out_drop_kind);
                check_field("dropped", want.dropped, o_dropped);
                check_field("dead", want.dead, o_dead);
            end
        end
    end

    initial begin : result_sink
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_results_long) begin
                i_ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++) @(posedge i_clk);
                hold_results_long = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("generational_handle_table test failed");
        $finish;
    end

    initial begin
        clear_slot_table();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;
        test_fresh_slots();
        test_full_table();
        test_result_backpressure();
        test_random_traffic();
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("generational_handle_table test passed");
        end else begin
            $display("generational_handle_table test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
sv/ght_pkg.sv
sv/generational_handle_table.sv
sv/ght_checker.sv
tb/generational_handle_table_test.sv
